@@ hw/rtl/nrmc_pkg.sv @@
// ----------------------------------------------------------------------------
// nrmc_pkg
// Shared constants, types and the field layout table of the RMC sentence
// parser.
// ----------------------------------------------------------------------------
package nrmc_pkg;

   // Default number of characters kept per field.
   localparam int FIELD_CHARS_DEFAULT = 14;

   // Characters with a meaning of their own.
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // Field numbers within the sentence.
   localparam logic [3:0] FIELD_TIME     = 4'd1;
   localparam logic [3:0] FIELD_STATUS   = 4'd2;
   localparam logic [3:0] FIELD_LAT      = 4'd3;
   localparam logic [3:0] FIELD_LAT_HEMI = 4'd4;
   localparam logic [3:0] FIELD_LON      = 4'd5;
   localparam logic [3:0] FIELD_LON_HEMI = 4'd6;
   localparam logic [3:0] FIELD_SPEED    = 4'd7;
   localparam logic [3:0] FIELD_DATE     = 4'd9;
   localparam logic [3:0] FIELD_MAX      = 4'd15;

   // Digit slices tracked per field.
   localparam int NUM_SLICES = 4;
   localparam int SLICE_W    = 14;

   // Scaling constants for the minute fraction and the speed.
   localparam logic [27:0] MM_WEIGHT    = 28'd1666666;
   localparam logic [27:0] FR_WEIGHT    = 28'd166;
   localparam logic [25:0] IP_SAT_LIMIT = 26'd4294968;
   localparam logic [32:0] MILLI_SCALE  = 33'd1000;
   localparam logic [31:0] SPEED_MAX    = 32'hFFFF_FFFF;

   // Character position range [lo, hi) of each slice.
   typedef struct packed {
      logic [NUM_SLICES-1:0][3:0] lo;
      logic [NUM_SLICES-1:0][3:0] hi;
   } slice_map_type;

   // Control from the sentence sequencer to the field accumulator.
   typedef struct packed {
      logic       store;
      logic       clear;
      logic [7:0] ch;
      logic [3:0] field;
   } acc_ctrl_type;

   // Everything the field accumulator has gathered for the current field.
   typedef struct packed {
      logic [7:0]                         first_char;
      logic [NUM_SLICES-1:0][SLICE_W-1:0] slice;
      logic [27:0]                        mm_q;
      logic [1:0]                         mm_r;
      logic [27:0]                        fr_q;
      logic [1:0]                         fr_r;
      logic [22:0]                        ip;
      logic                               ip_big;
      logic [9:0]                         fp;
   } acc_values_type;

   // Slice layout of each field; fields without slices get empty ranges.
   function automatic slice_map_type slice_map(input logic [3:0] field);
      slice_map_type m;
      m = '0;
      unique case (field)
         FIELD_TIME: begin
            m.lo[0] = 4'd0; m.hi[0] = 4'd2;
            m.lo[1] = 4'd2; m.hi[1] = 4'd4;
            m.lo[2] = 4'd4; m.hi[2] = 4'd6;
            m.lo[3] = 4'd7; m.hi[3] = 4'd10;
         end
         FIELD_LAT: begin
            m.lo[0] = 4'd0; m.hi[0] = 4'd2;
            m.lo[1] = 4'd2; m.hi[1] = 4'd4;
            m.lo[3] = 4'd5; m.hi[3] = 4'd9;
         end
         FIELD_LON: begin
            m.lo[0] = 4'd0; m.hi[0] = 4'd3;
            m.lo[1] = 4'd3; m.hi[1] = 4'd5;
            m.lo[3] = 4'd6; m.hi[3] = 4'd10;
         end
         FIELD_DATE: begin
            m.lo[0] = 4'd0; m.hi[0] = 4'd2;
            m.lo[1] = 4'd2; m.hi[1] = 4'd4;
            m.lo[2] = 4'd4; m.hi[2] = 4'd6;
         end
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

@@ hw/rtl/nrmc_field_acc.sv @@
// ----------------------------------------------------------------------------
// nrmc_field_acc
// Accumulates one field character by character: the digit slices, the
// minute fraction as quotient and remainder by three, and the speed.
// ----------------------------------------------------------------------------
module nrmc_field_acc #(
   parameter int FIELD_CHARS = nrmc_pkg::FIELD_CHARS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  nrmc_pkg::acc_ctrl_type   ctrl,
   output nrmc_pkg::acc_values_type values
);

   localparam int CPOS_W = $clog2(FIELD_CHARS + 1);

   logic [CPOS_W-1:0]                 pos_ff, pos_in;
   nrmc_pkg::acc_values_type          val_ff, val_in;
   logic [nrmc_pkg::NUM_SLICES-1:0]   live_ff, live_in;
   logic                              int_live_ff, int_live_in;
   logic                              frac_on_ff, frac_on_in;
   logic [1:0]                        frac_k_ff, frac_k_in;
   logic                              frac_live_ff, frac_live_in;

   nrmc_pkg::slice_map_type           map;
   logic [nrmc_pkg::NUM_SLICES-1:0]   take;
   logic                              upd;
   logic                              dig;
   logic [3:0]                        d;
   logic [25:0]                       ip_next;
   logic [9:0]                        frac_add;
   logic [29:0]                       mm_step;
   logic [29:0]                       fr_step;

   // Quotient by three of a value below 39, by reciprocal multiply.
   function automatic logic [3:0] div3_small(input logic [5:0] u);
      logic [11:0] p;
      p = 12'(u) * 12'd43;
      return p[10:7];
   endfunction

   // One decimal digit into v * (3 * weight + 2), kept as quotient q and
   // remainder r by three; every digit weight is congruent to two modulo three.
   function automatic logic [29:0] third_step(input logic [27:0] q, input logic [1:0] r,
                                              input logic [3:0] dd, input logic [27:0] weight);
      logic [5:0]  u;
      logic [3:0]  qs;
      logic [27:0] qn;
      logic [5:0]  rn;
      u  = 6'(r) * 6'd10 + 6'(dd) * 6'd2;
      qs = div3_small(u);
      qn = 28'(q * 28'd10) + 28'(28'(dd) * weight) + 28'(qs);
      rn = u - 6'(qs) * 6'd3;
      return {qn, rn[1:0]};
   endfunction

   // Character update.
   always_comb begin
      map          = nrmc_pkg::slice_map(ctrl.field);
      dig          = (ctrl.ch >= nrmc_pkg::CHAR_ZERO) && (ctrl.ch <= nrmc_pkg::CHAR_NINE);
      d            = 4'(ctrl.ch - nrmc_pkg::CHAR_ZERO);
      upd          = ctrl.store && (pos_ff < CPOS_W'(FIELD_CHARS));
      pos_in       = pos_ff;
      val_in       = val_ff;
      live_in      = live_ff;
      int_live_in  = int_live_ff;
      frac_on_in   = frac_on_ff;
      frac_k_in    = frac_k_ff;
      frac_live_in = frac_live_ff;
      take         = '0;
      ip_next      = 26'(val_ff.ip) * 26'd10 + 26'(d);
      mm_step      = third_step(val_ff.mm_q, val_ff.mm_r, d, nrmc_pkg::MM_WEIGHT);
      fr_step      = third_step(val_ff.fr_q, val_ff.fr_r, d, nrmc_pkg::FR_WEIGHT);
      case (frac_k_ff)
         2'd0:    frac_add = 10'(d) * 10'd100;
         2'd1:    frac_add = 10'(d) * 10'd10;
         default: frac_add = 10'(d);
      endcase

      if (upd) begin
         pos_in = pos_ff + CPOS_W'(1);
         if (pos_ff == '0) begin
            val_in.first_char = ctrl.ch;
         end

         // Leading-digit slices: a non-digit ends the slice value.
         for (int k = 0; k < nrmc_pkg::NUM_SLICES; k++) begin
            if ((pos_ff >= CPOS_W'(map.lo[k])) && (pos_ff < CPOS_W'(map.hi[k]))) begin
               if (live_ff[k] && dig) begin
                  take[k]         = 1'b1;
                  val_in.slice[k] = nrmc_pkg::SLICE_W'(val_ff.slice[k] *
                                    nrmc_pkg::SLICE_W'(10)) + nrmc_pkg::SLICE_W'(d);
               end else begin
                  live_in[k] = 1'b0;
               end
            end
         end

         // Minutes and minute fraction feed the degree fraction.
         if (take[1]) begin
            val_in.mm_q = mm_step[29:2];
            val_in.mm_r = mm_step[1:0];
         end
         if (take[3]) begin
            val_in.fr_q = fr_step[29:2];
            val_in.fr_r = fr_step[1:0];
         end

         // Speed: integer digits, then up to three digits after a dot.
         if (int_live_ff) begin
            if (dig) begin
               if (val_ff.ip_big || (ip_next >= nrmc_pkg::IP_SAT_LIMIT)) begin
                  val_in.ip_big = 1'b1;
               end else begin
                  val_in.ip = ip_next[22:0];
               end
            end else begin
               int_live_in = 1'b0;
               frac_on_in  = (ctrl.ch == nrmc_pkg::CHAR_DOT);
            end
         end else if (frac_on_ff && (frac_k_ff != 2'd3)) begin
            if (frac_live_ff && dig) begin
               val_in.fp = val_ff.fp + frac_add;
            end else begin
               frac_live_in = 1'b0;
            end
            frac_k_in = frac_k_ff + 2'd1;
         end
      end

      values = val_in;
   end

   // Field registers, emptied on reset and when the field closes.
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         pos_ff       <= '0;
         val_ff       <= '0;
         live_ff      <= '1;
         int_live_ff  <= 1'b1;
         frac_on_ff   <= 1'b0;
         frac_k_ff    <= 2'd0;
         frac_live_ff <= 1'b1;
      end else begin
         pos_ff       <= pos_in;
         val_ff       <= val_in;
         live_ff      <= live_in;
         int_live_ff  <= int_live_in;
         frac_on_ff   <= frac_on_in;
         frac_k_ff    <= frac_k_in;
         frac_live_ff <= frac_live_in;
      end
   end

endmodule

@@ hw/rtl/nmea_rmc_sentence_parser.sv @@
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser
// Order: an accepted final byte waits in the input register, then loads the
// result register.
// Throughput: one byte per cycle; the final byte of a sentence waits in the
// input register only while the previous result has not been taken.
// Reset clears the control state and all held sentence values; there is no
// clearing pass.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser #(
   parameter int FIELD_CHARS = nrmc_pkg::FIELD_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_sentence,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_sentence_ok,
   output logic [30:0] rsp_utc_time,
   output logic [20:0] rsp_utc_date,
   output logic [7:0]  rsp_fix_status,
   output logic [6:0]  rsp_lat_degrees,
   output logic [27:0] rsp_lat_fraction,
   output logic [7:0]  rsp_lat_hemisphere,
   output logic [9:0]  rsp_lon_degrees,
   output logic [27:0] rsp_lon_fraction,
   output logic [7:0]  rsp_lon_hemisphere,
   output logic [31:0] rsp_speed_milliknots
);

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_char_ff, in_char_in;
   logic        in_eos_ff, in_eos_in;

   // Sentence state.
   logic [3:0]  field_ff, field_in;
   logic        start_ff, start_in;
   logic        reject_ff, reject_in;
   logic [30:0] time_ff, time_in;
   logic [20:0] date_ff, date_in;
   logic [7:0]  status_ff, status_in;
   logic [6:0]  lat_deg_ff, lat_deg_in;
   logic [27:0] lat_frac_ff, lat_frac_in;
   logic [7:0]  lat_hemi_ff, lat_hemi_in;
   logic [9:0]  lon_deg_ff, lon_deg_in;
   logic [27:0] lon_frac_ff, lon_frac_in;
   logic [7:0]  lon_hemi_ff, lon_hemi_in;
   logic [31:0] speed_ff, speed_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [30:0] rsp_time_ff, rsp_time_in;
   logic [20:0] rsp_date_ff, rsp_date_in;
   logic [7:0]  rsp_status_ff, rsp_status_in;
   logic [6:0]  rsp_lat_deg_ff, rsp_lat_deg_in;
   logic [27:0] rsp_lat_frac_ff, rsp_lat_frac_in;
   logic [7:0]  rsp_lat_hemi_ff, rsp_lat_hemi_in;
   logic [9:0]  rsp_lon_deg_ff, rsp_lon_deg_in;
   logic [27:0] rsp_lon_frac_ff, rsp_lon_frac_in;
   logic [7:0]  rsp_lon_hemi_ff, rsp_lon_hemi_in;
   logic [31:0] rsp_speed_ff, rsp_speed_in;

   logic                      req_fire;
   logic                      consume;
   logic                      is_comma;
   logic                      close;
   logic                      rejected_now;
   nrmc_pkg::acc_ctrl_type    acc_ctrl;
   nrmc_pkg::acc_values_type  vals;

   // Degree fraction: the two partial quotients plus the carry of their
   // remainders.
   function automatic logic [27:0] coord_fraction(input nrmc_pkg::acc_values_type v);
      logic [2:0] rsum;
      rsum = 3'(v.mm_r) + 3'(v.fr_r);
      return v.mm_q + v.fr_q + 28'(rsum >= 3'd3);
   endfunction

   // Speed in thousandths of a knot, saturating.
   function automatic logic [31:0] speed_scale(input nrmc_pkg::acc_values_type v);
      logic [32:0] sum;
      sum = 33'(v.ip) * nrmc_pkg::MILLI_SCALE + 33'(v.fp);
      if (v.ip_big || sum[32]) begin
         return nrmc_pkg::SPEED_MAX;
      end
      return sum[31:0];
   endfunction

   nrmc_field_acc #(
      .FIELD_CHARS(FIELD_CHARS)
   ) u_field_acc (
      .clock (clock),
      .reset (reset),
      .ctrl  (acc_ctrl),
      .values(vals)
   );

   // Handshake: only a final byte waits for the result register.
   always_comb begin
      req_fire    = req_valid && req_ready;
      consume     = in_valid_ff && (!in_eos_ff || !rsp_valid_ff || rsp_ready);
      req_ready   = !in_valid_ff || consume;
      in_valid_in = req_fire || (in_valid_ff && !consume);
      in_char_in  = req_fire ? req_rx_byte : in_char_ff;
      in_eos_in   = req_fire ? req_end_of_sentence : in_eos_ff;
   end

   // Field sequencing and closing.
   always_comb begin
      is_comma     = (in_char_ff == nrmc_pkg::CHAR_COMMA);
      close        = is_comma || in_eos_ff;
      rejected_now = start_ff ? (in_char_ff != nrmc_pkg::CHAR_DOLLAR) : reject_ff;

      acc_ctrl.store = consume && !is_comma;
      acc_ctrl.clear = consume && close;
      acc_ctrl.ch    = in_char_ff;
      acc_ctrl.field = field_ff;

      field_in    = field_ff;
      start_in    = start_ff;
      reject_in   = reject_ff;
      time_in     = time_ff;
      date_in     = date_ff;
      status_in   = status_ff;
      lat_deg_in  = lat_deg_ff;
      lat_frac_in = lat_frac_ff;
      lat_hemi_in = lat_hemi_ff;
      lon_deg_in  = lon_deg_ff;
      lon_frac_in = lon_frac_ff;
      lon_hemi_in = lon_hemi_ff;
      speed_in    = speed_ff;

      if (consume) begin
         // A closing field updates its held value unless the sentence was rejected.
         if (close && !rejected_now) begin
            unique case (field_ff)
               nrmc_pkg::FIELD_TIME: begin
                  time_in = {vals.slice[0][6:0], vals.slice[1][6:0],
                             vals.slice[2][6:0], vals.slice[3][9:0]};
               end
               nrmc_pkg::FIELD_STATUS: status_in = vals.first_char;
               nrmc_pkg::FIELD_LAT: begin
                  if (vals.first_char == '0) begin
                     lat_deg_in  = '0;
                     lat_frac_in = '0;
                  end else begin
                     lat_deg_in  = vals.slice[0][6:0];
                     lat_frac_in = coord_fraction(vals);
                  end
               end
               nrmc_pkg::FIELD_LAT_HEMI: lat_hemi_in = vals.first_char;
               nrmc_pkg::FIELD_LON: begin
                  if (vals.first_char == '0) begin
                     lon_deg_in  = '0;
                     lon_frac_in = '0;
                  end else begin
                     lon_deg_in  = vals.slice[0][9:0];
                     lon_frac_in = coord_fraction(vals);
                  end
               end
               nrmc_pkg::FIELD_LON_HEMI: lon_hemi_in = vals.first_char;
               nrmc_pkg::FIELD_SPEED: speed_in = speed_scale(vals);
               nrmc_pkg::FIELD_DATE: begin
                  date_in = {vals.slice[0][6:0], vals.slice[1][6:0], vals.slice[2][6:0]};
               end
               default: begin
               end
            endcase
         end

         // Field count saturates; the final byte rearms for a new sentence.
         if (in_eos_ff) begin
            field_in  = '0;
            start_in  = 1'b1;
            reject_in = 1'b0;
         end else begin
            start_in  = 1'b0;
            reject_in = rejected_now;
            if (close && (field_ff != nrmc_pkg::FIELD_MAX)) begin
               field_in = field_ff + 4'd1;
            end
         end
      end
   end

   // Result register loads the held values as they stand after the final byte.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_ok_in       = rsp_ok_ff;
      rsp_time_in     = rsp_time_ff;
      rsp_date_in     = rsp_date_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_lat_deg_in  = rsp_lat_deg_ff;
      rsp_lat_frac_in = rsp_lat_frac_ff;
      rsp_lat_hemi_in = rsp_lat_hemi_ff;
      rsp_lon_deg_in  = rsp_lon_deg_ff;
      rsp_lon_frac_in = rsp_lon_frac_ff;
      rsp_lon_hemi_in = rsp_lon_hemi_ff;
      rsp_speed_in    = rsp_speed_ff;
      if (consume && in_eos_ff) begin
         rsp_valid_in    = 1'b1;
         rsp_ok_in       = !rejected_now;
         rsp_time_in     = time_in;
         rsp_date_in     = date_in;
         rsp_status_in   = status_in;
         rsp_lat_deg_in  = lat_deg_in;
         rsp_lat_frac_in = lat_frac_in;
         rsp_lat_hemi_in = lat_hemi_in;
         rsp_lon_deg_in  = lon_deg_in;
         rsp_lon_frac_in = lon_frac_in;
         rsp_lon_hemi_in = lon_hemi_in;
         rsp_speed_in    = speed_in;
      end
   end

   // Control and held-value registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         field_ff     <= '0;
         start_ff     <= 1'b1;
         reject_ff    <= 1'b0;
         time_ff      <= '0;
         date_ff      <= '0;
         status_ff    <= '0;
         lat_deg_ff   <= '0;
         lat_frac_ff  <= '0;
         lat_hemi_ff  <= '0;
         lon_deg_ff   <= '0;
         lon_frac_ff  <= '0;
         lon_hemi_ff  <= '0;
         speed_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         field_ff     <= field_in;
         start_ff     <= start_in;
         reject_ff    <= reject_in;
         time_ff      <= time_in;
         date_ff      <= date_in;
         status_ff    <= status_in;
         lat_deg_ff   <= lat_deg_in;
         lat_frac_ff  <= lat_frac_in;
         lat_hemi_ff  <= lat_hemi_in;
         lon_deg_ff   <= lon_deg_in;
         lon_frac_ff  <= lon_frac_in;
         lon_hemi_ff  <= lon_hemi_in;
         speed_ff     <= speed_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_char_ff      <= in_char_in;
      in_eos_ff       <= in_eos_in;
      rsp_ok_ff       <= rsp_ok_in;
      rsp_time_ff     <= rsp_time_in;
      rsp_date_ff     <= rsp_date_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_lat_deg_ff  <= rsp_lat_deg_in;
      rsp_lat_frac_ff <= rsp_lat_frac_in;
      rsp_lat_hemi_ff <= rsp_lat_hemi_in;
      rsp_lon_deg_ff  <= rsp_lon_deg_in;
      rsp_lon_frac_ff <= rsp_lon_frac_in;
      rsp_lon_hemi_ff <= rsp_lon_hemi_in;
      rsp_speed_ff    <= rsp_speed_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sentence_ok      = rsp_ok_ff;
   assign rsp_utc_time         = rsp_time_ff;
   assign rsp_utc_date         = rsp_date_ff;
   assign rsp_fix_status       = rsp_status_ff;
   assign rsp_lat_degrees      = rsp_lat_deg_ff;
   assign rsp_lat_fraction     = rsp_lat_frac_ff;
   assign rsp_lat_hemisphere   = rsp_lat_hemi_ff;
   assign rsp_lon_degrees      = rsp_lon_deg_ff;
   assign rsp_lon_fraction     = rsp_lon_frac_ff;
   assign rsp_lon_hemisphere   = rsp_lon_hemi_ff;
   assign rsp_speed_milliknots = rsp_speed_ff;

endmodule

@@ hw/rtl/nrmc_checker.sv @@
// ----------------------------------------------------------------------------
// nrmc_checker
// Port-level checks of the RMC sentence parser, bound to the top level.
// ----------------------------------------------------------------------------
module nrmc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_end_of_sentence,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_sentence_ok,
   input logic [30:0] rsp_utc_time,
   input logic [31:0] rsp_speed_milliknots
);

   // Sentences whose final byte went in and whose result has not come out.
   logic [1:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff + 2'(req_valid && req_ready && req_end_of_sentence)
                        - 2'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A waiting result holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sentence_ok) &&
      $stable(rsp_utc_time) && $stable(rsp_speed_milliknots))
      else $error("result changed while stalled");

   // Every result belongs to a final byte that went in.
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without a finished sentence");

   // At most one sentence waits in the input register and one in the output.
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many finished sentences in flight");

   // Input stalls only behind a result that is not taken.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with the result side free");

endmodule

bind nmea_rmc_sentence_parser nrmc_checker u_nrmc_checker (.*);
